>>> sv/dels_pkg.sv
// Package for the double-ended list store: item types, codes and shared control structs.
`timescale 1ns / 1ps
package dels_pkg;

    // Default capacity of the list
    localparam int CAPACITY_DEF = 64;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_FWD   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_REV   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Input item
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
    } request_t;

    // Result item
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] element;
        logic [COUNT_W-1:0]       element_count;
        logic                     last;
    } result_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // item accepted this cycle
        logic rd_step;  // read out one element this cycle
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;    // no elements stored
        logic rd_last;  // current readout step is the final one
    } dp_status_t;

endpackage

>>> sv/double_ended_list_store.sv
// Top level of the double-ended list store: controller, datapath and checks.
//
// Usage: a bounded double-ended queue of signed 32-bit values in a ring memory.
// An item (request: operation, value) is accepted at a rising edge with start
// high and busy low. Results appear on result for exactly one cycle, marked by
// result_valid; the receiver cannot stall them.
// Push and pop: one result, in the cycle after the item is accepted; a new item
// may be accepted every cycle.
// Readout of N elements: busy is high while one element per cycle is read from
// the single memory read port; results follow in the next cycle, the final one
// carrying last. An empty readout gives one status result.
// So a readout item holds off the next item until busy falls; push/pop/other
// items do not set busy.
// Push on a full list or pop/readout on an empty one gives one status result
// and leaves the list unchanged.
// Reset (rst_n low) empties the list and returns to idle; memory contents are
// not cleared, since only pushed entries are ever read.
`timescale 1ns / 1ps
module double_ended_list_store #(
    parameter int CAPACITY = dels_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dels_pkg::request_t request,
    output logic               result_valid,
    output dels_pkg::result_t  result
);
    import dels_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Controller
    dels_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .status    (dp_status),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Datapath
    dels_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .status       (dp_status),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.element_count <= COUNT_W'(CAPACITY)))
        else $error("element count above capacity");

    // Error status results are single and carry no element
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (result.last && result.element == '0))
        else $error("error result not final or has element");

    // A push or pop gives its final result in the next cycle
    a_single_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == OP_PUSH_FRONT ||
         request.operation == OP_PUSH_BACK || request.operation == OP_POP_FRONT ||
         request.operation == OP_POP_BACK)) |=> (result_valid && result.last))
        else $error("push/pop result missing");

    // The final result of an item never shows while the block is busy
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result while busy");
`endif

endmodule

>>> sv/dels_ctrl.sv
// Controller for the double-ended list store: idle/readout state machine.
`timescale 1ns / 1ps
module dels_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [dels_pkg::OP_W-1:0] operation,
    input  dels_pkg::dp_status_t  status,
    output logic                  busy,
    output dels_pkg::ctrl_cmd_t   cmd
);
    import dels_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   is_readout;

    // Commands
    assign cmd.load    = start && !busy_reg;
    assign cmd.rd_step = (state_reg == S_READ);
    assign busy        = busy_reg;

    assign is_readout = (operation == OP_READ_FWD) || (operation == OP_READ_REV);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load && is_readout && !status.empty)
                begin
                    state_next = S_READ;
                    busy_next  = 1'b1;
                end
            end
            S_READ:
            begin
                if (status.rd_last)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

>>> sv/dels_dp.sv
// Datapath for the double-ended list store: ring memory, head, count and result register.
`timescale 1ns / 1ps
module dels_dp #(
    parameter int CAPACITY = dels_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dels_pkg::ctrl_cmd_t  cmd,
    input  dels_pkg::request_t   request,
    output dels_pkg::dp_status_t status,
    output logic                 result_valid,
    output dels_pkg::result_t    result
);
    import dels_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;

    // Element memory, no reset: only pushed entries are read
    logic [DATA_W-1:0] mem [CAPACITY];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rev_reg, rev_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_last_reg, out_last_next;
    logic              out_mem_reg, out_mem_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  back_addr;
    logic [IDX_W-1:0]  rd_offset;
    logic [IDX_W-1:0]  head_dec, head_inc;
    logic              full;

    // Ring position of head plus an offset, both below CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(CAPACITY))
            sum = sum - SUM_W'(CAPACITY);
        return sum[IDX_W-1:0];
    endfunction

    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign status.empty = (count_reg == '0);
    assign status.rd_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    assign head_dec  = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign head_inc  = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);
    assign back_addr = ring_add(head_reg, count_reg[IDX_W-1:0]);

    // Readout address: forward walks up from head, reverse walks down from tail
    assign rd_offset = rev_reg ? IDX_W'(count_reg - CNT_W'(1) - CNT_W'(idx_reg)) : idx_reg;
    assign rd_addr   = ring_add(head_reg, rd_offset);

    // Operation decode and state update
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rev_next        = rev_reg;
        wr_en           = 1'b0;
        wr_addr         = back_addr;
        out_valid_next  = 1'b0;
        out_status_next = ST_OK;
        out_count_next  = count_reg;
        out_last_next   = 1'b1;
        out_mem_next    = 1'b0;

        if (cmd.rd_step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = status.rd_last;
            out_mem_next   = 1'b1;
            idx_next       = idx_reg + IDX_W'(1);
        end
        else if (cmd.load)
        begin
            out_valid_next = 1'b1;
            case (request.operation)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (full)
                        out_status_next = ST_FULL;
                    else
                    begin
                        wr_en = 1'b1;
                        if (request.operation == OP_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            wr_addr   = head_dec;
                        end
                        count_next     = count_reg + CNT_W'(1);
                        out_count_next = count_next;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (status.empty)
                        out_status_next = ST_EMPTY;
                    else
                    begin
                        if (request.operation == OP_POP_FRONT)
                            head_next = head_inc;
                        count_next     = count_reg - CNT_W'(1);
                        out_count_next = count_next;
                    end
                end
                OP_READ_FWD, OP_READ_REV:
                begin
                    if (status.empty)
                        out_status_next = ST_EMPTY;
                    else
                    begin
                        // results come from the readout steps
                        out_valid_next = 1'b0;
                        idx_next       = '0;
                        rev_next       = (request.operation == OP_READ_REV);
                    end
                end
                default:
                begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
        out_mem_reg    <= out_mem_next;
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= request.value;
    end

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Result port
    assign result_valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.element       = out_mem_reg ? rd_data_reg : '0;
    assign result.element_count = COUNT_W'(out_count_reg);
    assign result.last          = out_last_reg;

endmodule
